/* hdl/gdr_pkg.sv */
// ----------------------------------------------------------------------------
// gdr_pkg
// shared types and constants of the grid dda column ray caster
// ----------------------------------------------------------------------------
package gdr_pkg;

    localparam int CFG_W   = 20;
    localparam int CFG_IW  = 3;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int DIST_W  = 24;
    localparam int CAM_W   = 28;
    localparam int RAY_W   = 30;
    localparam int PROD_W  = 46;
    localparam int LH_W    = 30;
    localparam int DIV_NW  = 40;
    localparam int DIV_DW  = 30;
    localparam int Q_ONE   = 65536;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [CFG_IW-1:0] CFG_POS_X   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_POS_Y   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_DIR_X   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DIR_Y   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_PLANE_X = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_PLANE_Y = 3'd5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    typedef enum logic [2:0] {
        SEL_DX,
        SEL_DY,
        SEL_DIST,
        SEL_LH
    } t_div_sel;

    typedef struct packed {
        logic     clr;
        logic     map_wr;
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     ray_mul;
        logic     ray_add;
        logic     side_init;
        logic     step;
        logic     set_esc;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic start_out;
        logic oob;
        logic wall;
    } t_sts;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [DIV_NW-1:0] q);
        logic [DIST_W-1:0] r;
        r = (|q[DIV_NW-1:DIST_W]) ? DIST_MAX : q[DIST_W-1:0];
        return r;
    endfunction

endpackage

/* hdl/grid_dda_column_raycaster_top.sv */
// ----------------------------------------------------------------------------
// grid_dda_column_raycaster_top
// tile map ray caster: one wall column per cast request
//
// channel   direction  handshake             payload
// request   in         start & !busy         i_operation i_column i_cell_*
// result    out        o_valid, one cycle    o_out_column .. o_status
// config    in         i_cfg_we              i_cfg_idx i_cfg_data
//
// map write request: taken while idle, busy stays low
// cast request: busy through four divisions, the grid steps, set-up and output;
// an escaping ray skips the last two divisions
// after reset a clearing pass over the whole map holds busy high
// result strobe lasts one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
module grid_dda_column_raycaster_top #(
    parameter int MAP_DIM  = 16,
    parameter int SCREEN_W = 640,
    parameter int SCREEN_H = 480
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_operation,
    input  logic [gdr_pkg::COL_W-1:0]  i_column,
    input  logic [3:0]                 i_cell_x,
    input  logic [3:0]                 i_cell_y,
    input  logic [7:0]                 i_cell_value,
    input  logic                       i_cfg_we,
    input  logic [gdr_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [gdr_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                       o_valid,
    output logic [gdr_pkg::COL_W-1:0]  o_out_column,
    output logic [gdr_pkg::ROW_W-1:0]  o_draw_top,
    output logic [gdr_pkg::ROW_W-1:0]  o_draw_bottom,
    output logic                       o_face,
    output logic [3:0]                 o_hit_x,
    output logic [3:0]                 o_hit_y,
    output logic [gdr_pkg::DIST_W-1:0] o_wall_distance,
    output logic                       o_status
);
    import gdr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gdr_ctrl #(
        .MAP_DIM (MAP_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .o_busy      (busy),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    gdr_dp #(
        .MAP_DIM  (MAP_DIM),
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_column        (i_column),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_cell_value    (i_cell_value),
        .o_valid         (o_valid),
        .o_out_column    (o_out_column),
        .o_draw_top      (o_draw_top),
        .o_draw_bottom   (o_draw_bottom),
        .o_face          (o_face),
        .o_hit_x         (o_hit_x),
        .o_hit_y         (o_hit_y),
        .o_wall_distance (o_wall_distance),
        .o_status        (o_status)
    );

endmodule

/* hdl/gdr_div.sv */
// ----------------------------------------------------------------------------
// gdr_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gdr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [gdr_pkg::DIV_NW-1:0] i_num,
    input  logic [gdr_pkg::DIV_DW-1:0] i_den,
    output logic                      o_done,
    output logic [gdr_pkg::DIV_NW-1:0] o_quo
);
    import gdr_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;

    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW+1:0] diff;
    logic              ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_NW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_den};
        ge     = ~diff[DIV_DW+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NW-2:0], ge};
            r_rem <= ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* hdl/gdr_dp.sv */
// ----------------------------------------------------------------------------
// gdr_dp
// datapath: camera registers, tile map, ray set-up, dda walk and wall span
// ----------------------------------------------------------------------------
module gdr_dp #(
    parameter int MAP_DIM  = 16,
    parameter int SCREEN_W = 640,
    parameter int SCREEN_H = 480
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gdr_pkg::t_cmd                i_cmd,
    output gdr_pkg::t_sts                o_sts,
    input  logic                         i_cfg_we,
    input  logic [gdr_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [gdr_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [gdr_pkg::COL_W-1:0]    i_column,
    input  logic [3:0]                   i_cell_x,
    input  logic [3:0]                   i_cell_y,
    input  logic [7:0]                   i_cell_value,
    output logic                         o_valid,
    output logic [gdr_pkg::COL_W-1:0]    o_out_column,
    output logic [gdr_pkg::ROW_W-1:0]    o_draw_top,
    output logic [gdr_pkg::ROW_W-1:0]    o_draw_bottom,
    output logic                         o_face,
    output logic [3:0]                   o_hit_x,
    output logic [3:0]                   o_hit_y,
    output logic [gdr_pkg::DIST_W-1:0]   o_wall_distance,
    output logic                         o_status
);
    import gdr_pkg::*;

    localparam int DEPTH = MAP_DIM * MAP_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (($clog2(MAP_DIM) > 4) ? $clog2(MAP_DIM) : 4) + 2;
    localparam int SW    = 25 + $clog2(4 * MAP_DIM + 5);
    localparam int NUMW  = CW + 18;
    localparam int H2    = SCREEN_H / 2;

    // reciprocal of the screen width for the camera coordinate
    localparam int              CAM_S = 27 + $clog2(SCREEN_W);
    localparam longint unsigned CAM_M = ((64'd1 << CAM_S) + 64'(SCREEN_W) - 64'd1)
                                        / 64'(SCREEN_W);

    // camera registers
    logic        [CFG_W-1:0] r_pos_x, r_pos_y;
    logic signed [17:0]      r_dir_x, r_dir_y, r_plane_x, r_plane_y;

    logic [AW-1:0] r_clr;
    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd;

    logic        [COL_W-1:0]  r_column;
    logic signed [CAM_W-1:0]  r_cam;
    logic signed [PROD_W-1:0] r_prod_x, r_prod_y;
    logic signed [RAY_W-1:0]  r_ray_x, r_ray_y;
    logic        [DIST_W-1:0] r_dlt_x, r_dlt_y;
    logic        [SW-1:0]     r_side_x, r_side_y;
    logic signed [CW-1:0]     r_mx, r_my;
    logic                     r_face, r_esc, r_oob;
    logic        [DIST_W-1:0] r_dist;
    logic        [LH_W-1:0]   r_lh;
    t_div_sel                 r_sel;

    logic                     r_valid;
    logic        [COL_W-1:0]  r_o_column;
    logic        [ROW_W-1:0]  r_o_top, r_o_bot;
    logic                     r_o_face;
    logic        [3:0]        r_o_hx, r_o_hy;
    logic        [DIST_W-1:0] r_o_dist;
    logic                     r_o_status;

    logic              div_done;
    logic [DIV_NW-1:0] div_quo;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;

    logic        [39:0]       cam_p;
    logic        [CAM_W-1:0]  cam_q;
    logic                     neg_x, neg_y;
    logic        [RAY_W-1:0]  abs_x, abs_y;
    logic signed [PROD_W-1:0] sh_x, sh_y;
    logic        [16:0]       fx, fy;
    logic        [40:0]       sp_x, sp_y;
    logic                     x_first;
    logic signed [CW-1:0]     nx, ny;
    logic                     oob_n;
    logic        [AW-1:0]     rd_addr;
    logic signed [CW-1:0]     hx;
    logic        [CFG_W-1:0]  hp;
    logic                     hn;
    logic signed [NUMW-1:0]   num_s;
    logic        [NUMW-1:0]   num_abs;
    logic        [LH_W-1:0]   half;
    logic        [LH_W:0]     top_v, bot_v;
    logic                     wr_ok;
    logic                     mem_we;
    logic        [AW-1:0]     mem_wa;
    logic        [7:0]        mem_wd;

    gdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        cam_p = 40'(i_column) * 40'(CAM_M);
        cam_q = CAM_W'(cam_p >> (CAM_S - 17));

        neg_x = r_ray_x[RAY_W-1];
        neg_y = r_ray_y[RAY_W-1];
        abs_x = neg_x ? RAY_W'(-r_ray_x) : RAY_W'(r_ray_x);
        abs_y = neg_y ? RAY_W'(-r_ray_y) : RAY_W'(r_ray_y);
        sh_x  = r_prod_x >>> 16;
        sh_y  = r_prod_y >>> 16;

        fx   = neg_x ? {1'b0, r_pos_x[15:0]} : 17'h10000 - {1'b0, r_pos_x[15:0]};
        fy   = neg_y ? {1'b0, r_pos_y[15:0]} : 17'h10000 - {1'b0, r_pos_y[15:0]};
        sp_x = 41'(fx) * 41'(r_dlt_x);
        sp_y = 41'(fy) * 41'(r_dlt_y);

        // next cell of the walk
        x_first = r_side_x < r_side_y;
        nx = r_mx;
        ny = r_my;
        if (x_first) begin
            nx = neg_x ? r_mx - CW'(1) : r_mx + CW'(1);
        end else begin
            ny = neg_y ? r_my - CW'(1) : r_my + CW'(1);
        end
        oob_n = (nx < 0) || (ny < 0) || (nx >= CW'(MAP_DIM)) || (ny >= CW'(MAP_DIM));
        rd_addr = oob_n ? '0 : AW'(int'(nx) * MAP_DIM + int'(ny));

        // boundary distance along the crossed face
        hx = r_face ? r_my : r_mx;
        hp = r_face ? r_pos_y : r_pos_x;
        hn = r_face ? neg_y : neg_x;
        num_s = (NUMW'(hx) <<< 16) - NUMW'($signed({1'b0, hp}))
              + (hn ? NUMW'(Q_ONE) : NUMW'(0));
        num_abs = num_s[NUMW-1] ? NUMW'(-num_s) : NUMW'(num_s);

        unique case (i_cmd.div_sel)
            SEL_DX: begin
                div_num = DIV_NW'(64'h1_0000_0000);
                div_den = DIV_DW'(abs_x);
            end
            SEL_DY: begin
                div_num = DIV_NW'(64'h1_0000_0000);
                div_den = DIV_DW'(abs_y);
            end
            SEL_DIST: begin
                div_num = DIV_NW'({num_abs, 16'h0});
                div_den = r_face ? DIV_DW'(abs_y) : DIV_DW'(abs_x);
            end
            SEL_LH: begin
                div_num = DIV_NW'(SCREEN_H) << 16;
                div_den = DIV_DW'(r_dist);
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase

        half  = r_lh >> 1;
        top_v = (half > LH_W'(H2)) ? '0 : (LH_W+1)'(LH_W'(H2) - half);
        bot_v = (LH_W+1)'(half) + (LH_W+1)'(H2);
        if (bot_v >= (LH_W+1)'(SCREEN_H)) begin
            bot_v = (LH_W+1)'(SCREEN_H - 1);
        end

        wr_ok  = (int'(i_cell_x) < MAP_DIM) && (int'(i_cell_y) < MAP_DIM);
        mem_we = i_cmd.clr || (i_cmd.map_wr && wr_ok);
        mem_wa = i_cmd.clr ? r_clr : AW'(int'(i_cell_x) * MAP_DIM + int'(i_cell_y));
        mem_wd = i_cmd.clr ? 8'h00 : i_cell_value;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[rd_addr];
    end

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= 20'd327680;
            r_pos_y   <= 20'd327680;
            r_dir_x   <= -18'sd65536;
            r_dir_y   <= 18'sd0;
            r_plane_x <= 18'sd0;
            r_plane_y <= 18'sd43254;
            r_clr     <= '0;
            r_valid   <= 1'b0;
            r_esc     <= 1'b0;
            r_sel     <= SEL_DX;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_POS_X:   r_pos_x   <= i_cfg_data;
                    CFG_POS_Y:   r_pos_y   <= i_cfg_data;
                    CFG_DIR_X:   r_dir_x   <= $signed(i_cfg_data[17:0]);
                    CFG_DIR_Y:   r_dir_y   <= $signed(i_cfg_data[17:0]);
                    CFG_PLANE_X: r_plane_x <= $signed(i_cfg_data[17:0]);
                    CFG_PLANE_Y: r_plane_y <= $signed(i_cfg_data[17:0]);
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.div_start) begin
                r_sel <= i_cmd.div_sel;
            end
            if (i_cmd.load) begin
                r_esc <= 1'b0;
            end else if (i_cmd.set_esc) begin
                r_esc <= 1'b1;
            end
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_column <= i_column;
            r_face   <= 1'b0;
            r_cam    <= $signed(cam_q) - CAM_W'(Q_ONE);
        end
        if (div_done) begin
            unique case (r_sel)
                SEL_DX:   r_dlt_x <= sat_dist(div_quo);
                SEL_DY:   r_dlt_y <= sat_dist(div_quo);
                SEL_DIST: r_dist  <= sat_dist(div_quo);
                SEL_LH:   r_lh    <= (r_dist == '0) ? LH_W'(2 * SCREEN_H)
                                                    : div_quo[LH_W-1:0];
                default: begin
                end
            endcase
        end
        if (i_cmd.ray_mul) begin
            r_prod_x <= PROD_W'(r_plane_x) * PROD_W'(r_cam);
            r_prod_y <= PROD_W'(r_plane_y) * PROD_W'(r_cam);
        end
        if (i_cmd.ray_add) begin
            r_ray_x <= RAY_W'(r_dir_x) + sh_x[RAY_W-1:0];
            r_ray_y <= RAY_W'(r_dir_y) + sh_y[RAY_W-1:0];
        end
        if (i_cmd.side_init) begin
            r_side_x <= SW'(sp_x[40:16]);
            r_side_y <= SW'(sp_y[40:16]);
            r_mx     <= $signed(CW'(r_pos_x[19:16]));
            r_my     <= $signed(CW'(r_pos_y[19:16]));
        end
        if (i_cmd.step) begin
            if (x_first) begin
                r_side_x <= r_side_x + SW'(r_dlt_x);
            end else begin
                r_side_y <= r_side_y + SW'(r_dlt_y);
            end
            r_mx   <= nx;
            r_my   <= ny;
            r_face <= ~x_first;
            r_oob  <= oob_n;
        end
        if (i_cmd.finish) begin
            r_o_column <= r_column;
            r_o_face   <= r_face;
            r_o_status <= r_esc;
            r_o_top    <= r_esc ? '0 : top_v[ROW_W-1:0];
            r_o_bot    <= r_esc ? '0 : bot_v[ROW_W-1:0];
            r_o_hx     <= r_esc ? '0 : r_mx[3:0];
            r_o_hy     <= r_esc ? '0 : r_my[3:0];
            r_o_dist   <= r_esc ? '0 : r_dist;
        end
    end

    always_comb begin
        o_sts.clr_last  = (r_clr == AW'(DEPTH - 1));
        o_sts.div_done  = div_done;
        o_sts.start_out = (int'(r_pos_x[19:16]) >= MAP_DIM) || (int'(r_pos_y[19:16]) >= MAP_DIM);
        o_sts.oob       = r_oob;
        o_sts.wall      = (r_rd != 8'h00);
    end

    assign o_valid         = r_valid;
    assign o_out_column    = r_o_column;
    assign o_draw_top      = r_o_top;
    assign o_draw_bottom   = r_o_bot;
    assign o_face          = r_o_face;
    assign o_hit_x         = r_o_hx;
    assign o_hit_y         = r_o_hy;
    assign o_wall_distance = r_o_dist;
    assign o_status        = r_o_status;

endmodule

/* hdl/gdr_ctrl.sv */
// ----------------------------------------------------------------------------
// gdr_ctrl
// sequencer: map clearing and writes, ray set-up, dda walk, distance and height divisions and result
// ----------------------------------------------------------------------------
module gdr_ctrl #(
    parameter int MAP_DIM = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_operation,
    output logic          o_busy,
    output gdr_pkg::t_cmd o_cmd,
    input  gdr_pkg::t_sts i_sts
);
    import gdr_pkg::*;

    localparam int LIM   = 4 * MAP_DIM + 4;
    localparam int CNT_W = $clog2(LIM + 1);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RAY_MUL, S_RAY_ADD,
        S_DX, S_DX_W, S_DY, S_DY_W, S_SIDE, S_STEP, S_TEST,
        S_DIST, S_DIST_W, S_LH, S_LH_W, S_OUT
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_operation == OP_CAST) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_RAY_MUL;
                    end else begin
                        o_cmd.map_wr = 1'b1;
                    end
                end
            end
            S_RAY_MUL: begin
                o_cmd.ray_mul = 1'b1;
                n_state       = S_RAY_ADD;
            end
            S_RAY_ADD: begin
                o_cmd.ray_add = 1'b1;
                n_state       = S_DX;
            end
            S_DX: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = SEL_DX;
                n_state         = S_DX_W;
            end
            S_DX_W: begin
                if (i_sts.div_done) n_state = S_DY;
            end
            S_DY: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = SEL_DY;
                n_state         = S_DY_W;
            end
            S_DY_W: begin
                if (i_sts.div_done) n_state = S_SIDE;
            end
            S_SIDE: begin
                o_cmd.side_init = 1'b1;
                if (i_sts.start_out) begin
                    o_cmd.set_esc = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = S_TEST;
            end
            S_TEST: begin
                priority if (i_sts.oob) begin
                    o_cmd.set_esc = 1'b1;
                    n_state       = S_OUT;
                end else if (i_sts.wall) begin
                    n_state = S_DIST;
                end else if (r_cnt == CNT_W'(LIM)) begin
                    o_cmd.set_esc = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_DIST: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = SEL_DIST;
                n_state         = S_DIST_W;
            end
            S_DIST_W: begin
                if (i_sts.div_done) n_state = S_LH;
            end
            S_LH: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = SEL_LH;
                n_state         = S_LH_W;
            end
            S_LH_W: begin
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_cnt <= '0;
            end else if (r_state == S_STEP) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* hdl/gdr_checker.sv */
// ----------------------------------------------------------------------------
// gdr_checker
// port level checks of the ray caster, bound to the top level
// ----------------------------------------------------------------------------
module gdr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       i_operation,
    input logic                       o_valid,
    input logic [gdr_pkg::ROW_W-1:0]  o_draw_top,
    input logic [gdr_pkg::ROW_W-1:0]  o_draw_bottom,
    input logic [3:0]                 o_hit_x,
    input logic [3:0]                 o_hit_y,
    input logic [gdr_pkg::DIST_W-1:0] o_wall_distance,
    input logic                       o_status
);
    import gdr_pkg::*;

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_operation == OP_WRITE) |=> !o_valid)
        else $error("map write produced a result");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a cast in progress");

    a_escaped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> (o_wall_distance == '0) && (o_hit_x == '0)
            && (o_hit_y == '0) && (o_draw_top == '0) && (o_draw_bottom == '0))
        else $error("escaped ray with nonzero hit fields");

endmodule

bind grid_dda_column_raycaster_top gdr_checker u_gdr_checker (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the grid dda column ray caster
//
// Fills the tile map and casts columns under a sequence of camera settings,
// the extreme ones among them. A scoreboard keeps its own copy of the map and
// the camera registers, traces every cast request and compares each result
// strobe field by field with the oldest traced column.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import gdr_pkg::*;

    localparam int      N_ITEMS     = 1550;
    localparam longint  CYCLE_LIMIT = 3000000;
    localparam int      DRAIN_WAIT  = 400;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  top;
        logic [ROW_W-1:0]  bottom;
        logic              face;
        logic [3:0]        hit_x;
        logic [3:0]        hit_y;
        logic [DIST_W-1:0] wall_dist;
        logic              status;
    } column_result_t;

    class raycast_scoreboard;
        bit [7:0]       tiles [256];
        bit [19:0]      cam_x, cam_y;
        longint         dir_x, dir_y, plane_x, plane_y;
        column_result_t traced_q [$];
        int             errors, casts, writes, hits, escapes;

        function new();
            foreach (tiles[i]) tiles[i] = '0;
            cam_x   = 20'd327680;
            cam_y   = 20'd327680;
            dir_x   = -65536;
            dir_y   = 0;
            plane_x = 0;
            plane_y = 43254;
        endfunction

        function longint sext18(logic [CFG_W-1:0] d);
            return longint'($signed(d[17:0]));
        endfunction

        function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] d);
            case (idx)
                CFG_POS_X:   cam_x   = d;
                CFG_POS_Y:   cam_y   = d;
                CFG_DIR_X:   dir_x   = sext18(d);
                CFG_DIR_Y:   dir_y   = sext18(d);
                CFG_PLANE_X: plane_x = sext18(d);
                CFG_PLANE_Y: plane_y = sext18(d);
                default: ;
            endcase
        endfunction

        function longint step_length(longint r);
            longint a, d;
            a = (r < 0) ? -r : r;
            if (a == 0) return longint'(DIST_MAX);
            d = (longint'(1) << 32) / a;
            return (d > longint'(DIST_MAX)) ? longint'(DIST_MAX) : d;
        endfunction

        function column_result_t trace_column(logic [COL_W-1:0] col);
            column_result_t r;
            longint cam, rdx, rdy, mx, my, sx, sy, num, den, wdist, lh, top, bot;
            longint dx, dy, sdx, sdy, fx, fy;
            int     face, esc, hit;
            face = 0; esc = 0; hit = 0;
            cam = (2 * longint'(col) * 65536) / 640 - 65536;
            rdx = dir_x + ((plane_x * cam) >>> 16);
            rdy = dir_y + ((plane_y * cam) >>> 16);
            mx  = longint'(cam_x >> 16);
            my  = longint'(cam_y >> 16);
            dx  = step_length(rdx);
            dy  = step_length(rdy);
            fx  = longint'(cam_x[15:0]);
            fy  = longint'(cam_y[15:0]);
            if (rdx < 0) sx = -1; else begin sx = 1; fx = 65536 - fx; end
            if (rdy < 0) sy = -1; else begin sy = 1; fy = 65536 - fy; end
            sdx = (fx * dx) >> 16;
            sdy = (fy * dy) >> 16;
            if (mx >= 16 || my >= 16) esc = 1;
            for (int i = 0; !esc && !hit && i < 68; i++) begin
                if (sdx < sdy) begin
                    sdx += dx; mx += sx; face = 0;
                end else begin
                    sdy += dy; my += sy; face = 1;
                end
                if (mx < 0 || my < 0 || mx >= 16 || my >= 16) esc = 1;
                else if (tiles[mx*16+my] != 0) hit = 1;
            end
            if (!hit) esc = 1;
            r = '0;
            r.column = col;
            r.face   = face[0];
            if (esc) begin
                r.status = 1'b1;
                escapes++;
                return r;
            end
            hits++;
            if (face == 0) begin
                num = mx * 65536 - longint'(cam_x) + (sx < 0 ? 65536 : 0);
                den = (rdx < 0) ? -rdx : rdx;
            end else begin
                num = my * 65536 - longint'(cam_y) + (sy < 0 ? 65536 : 0);
                den = (rdy < 0) ? -rdy : rdy;
            end
            if (num < 0) num = -num;
            if (den == 0) wdist = longint'(DIST_MAX);
            else begin
                wdist = (num << 16) / den;
                if (wdist > longint'(DIST_MAX)) wdist = longint'(DIST_MAX);
            end
            lh  = (wdist == 0) ? 960 : (longint'(480) << 16) / wdist;
            top = 240 - lh / 2;
            if (top < 0) top = 0;
            bot = 240 + lh / 2;
            if (bot >= 480) bot = 479;
            r.top       = top[ROW_W-1:0];
            r.bottom    = bot[ROW_W-1:0];
            r.hit_x     = mx[3:0];
            r.hit_y     = my[3:0];
            r.wall_dist = wdist[DIST_W-1:0];
            return r;
        endfunction

        function void note_request(logic op, logic [COL_W-1:0] col, logic [3:0] cx,
                                   logic [3:0] cy, logic [7:0] val);
            if (op == OP_WRITE) begin
                tiles[{cx, cy}] = val;
                writes++;
            end else begin
                traced_q.push_back(trace_column(col));
                casts++;
            end
        endfunction

        function int pending();
            return traced_q.size();
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        endtask

        task check_result(column_result_t got);
            column_result_t want;
            if (traced_q.size() == 0) begin
                report("result with no cast request waiting", got.column, -1);
                return;
            end
            want = traced_q.pop_front();
            if (got.column !== want.column) report("out_column", got.column, want.column);
            if (got.top    !== want.top)    report("draw_top", got.top, want.top);
            if (got.bottom !== want.bottom) report("draw_bottom", got.bottom, want.bottom);
            if (got.face   !== want.face)   report("face", got.face, want.face);
            if (got.hit_x  !== want.hit_x)  report("hit_x", got.hit_x, want.hit_x);
            if (got.hit_y  !== want.hit_y)  report("hit_y", got.hit_y, want.hit_y);
            if (got.wall_dist !== want.wall_dist)
                report("wall_distance", got.wall_dist, want.wall_dist);
            if (got.status !== want.status) report("status", got.status, want.status);
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_operation = 1'b0;
    logic [COL_W-1:0]  i_column = '0;
    logic [3:0]        i_cell_x = '0;
    logic [3:0]        i_cell_y = '0;
    logic [7:0]        i_cell_value = '0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              o_valid;
    logic [COL_W-1:0]  o_out_column;
    logic [ROW_W-1:0]  o_draw_top;
    logic [ROW_W-1:0]  o_draw_bottom;
    logic              o_face;
    logic [3:0]        o_hit_x;
    logic [3:0]        o_hit_y;
    logic [DIST_W-1:0] o_wall_distance;
    logic              o_status;

    raycast_scoreboard sb = new();
    longint            cycles = 0;
    int                sent = 0;
    int                phases = 0;
    bit                no_gaps = 1'b0;

    grid_dda_column_raycaster_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_column        (i_column),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_cell_value    (i_cell_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_out_column    (o_out_column),
        .o_draw_top      (o_draw_top),
        .o_draw_bottom   (o_draw_bottom),
        .o_face          (o_face),
        .o_hit_x         (o_hit_x),
        .o_hit_y         (o_hit_y),
        .o_wall_distance (o_wall_distance),
        .o_status        (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("grid_dda_column_raycaster_top: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.set_reg(i_cfg_idx, i_cfg_data);
            if (start && !busy)
                sb.note_request(i_operation, i_column, i_cell_x, i_cell_y, i_cell_value);
            if (o_valid)
                sb.check_result({o_out_column, o_draw_top, o_draw_bottom, o_face,
                                 o_hit_x, o_hit_y, o_wall_distance, o_status});
        end
    end

    function int pick_gap();
        int p;
        if (no_gaps) return 0;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task send_request(logic op, logic [COL_W-1:0] col, logic [3:0] cx, logic [3:0] cy,
                      logic [7:0] val);
        int gap;
        gap          = pick_gap();
        start        <= 1'b1;
        i_operation  <= op;
        i_column     <= col;
        i_cell_x     <= cx;
        i_cell_y     <= cy;
        i_cell_value <= val;
        do @(posedge i_clk); while (busy);
        sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task write_cell(int x, int y, int v);
        send_request(OP_WRITE, COL_W'($urandom), x[3:0], y[3:0], v[7:0]);
    endtask

    task cast_column(int c);
        send_request(OP_CAST, c[COL_W-1:0], 4'($urandom), 4'($urandom), 8'($urandom));
    endtask

    task wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function logic [CFG_W-1:0] pick_dir();
        logic [CFG_W-1:0] hi;
        hi = CFG_W'($urandom_range(0, 3)) << 18;
        case ($urandom_range(0, 6))
            0:       return hi | 20'h20000;
            1:       return hi | 20'h1FFFF;
            2:       return hi;
            3:       return hi | 20'h10000;
            4:       return hi | 20'h30000;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    function logic [CFG_W-1:0] pick_pos();
        case ($urandom_range(0, 9))
            0:       return 20'h00000;
            1:       return 20'hFFFFF;
            2:       return {4'($urandom_range(1, 14)), 16'hFFFF};
            3:       return {4'($urandom_range(1, 14)), 16'h0000};
            default: return {4'($urandom_range(1, 14)), 16'($urandom)};
        endcase
    endfunction

    task random_camera();
        write_reg(CFG_POS_X, pick_pos());
        write_reg(CFG_POS_Y, pick_pos());
        write_reg(CFG_DIR_X, pick_dir());
        write_reg(CFG_DIR_Y, pick_dir());
        write_reg(CFG_PLANE_X, pick_dir());
        write_reg(CFG_PLANE_Y, pick_dir());
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IW'($urandom_range(6, 7)), CFG_W'($urandom));
    endtask

    task wall_border();
        for (int k = 0; k < 16; k++) begin
            write_cell(k, 0, $urandom_range(1, 255));
            write_cell(k, 15, $urandom_range(1, 255));
            write_cell(0, k, $urandom_range(1, 255));
            write_cell(15, k, $urandom_range(1, 255));
        end
    endtask

    function int pick_column();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(640, 1023);
            1:       return ($urandom_range(0, 1) == 0) ? 0 : 639;
            default: return $urandom_range(0, 639);
        endcase
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // empty map: every ray leaves the map
        cast_column(0);
        cast_column(320);
        cast_column(639);
        cast_column(1023);
        write_cell(2, 5, 255);
        write_cell(3, 4, 1);
        write_cell(15, 15, 255);
        write_cell(0, 0, 1);
        write_cell(9, 9, 128);
        cast_column(320);
        cast_column(0);
        cast_column(639);
        cast_column(700);
        // wall right next to the camera
        write_cell(4, 5, 7);
        cast_column(320);
        write_cell(4, 5, 0);
        write_cell(2, 5, 0);
        cast_column(320);
        wait_idle();

        // both ray components zero: the crossed face saturates the distance
        write_reg(CFG_DIR_X, 20'h0);
        write_reg(CFG_PLANE_Y, 20'h0);
        write_reg(CFG_POS_X, 20'h5FFFF);
        write_cell(6, 5, 3);
        cast_column(320);
        cast_column(5);
        wait_idle();

        wall_border();
        wait_idle();

        while (sent < N_ITEMS) begin
            int n_casts;
            phases++;
            random_camera();
            no_gaps = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(4, 12))
                write_cell($urandom_range(1, 14), $urandom_range(1, 14),
                           ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 255));
            if ($urandom_range(0, 5) == 0)
                write_cell($urandom_range(0, 15), 0, $urandom_range(0, 1) * 200);
            n_casts = $urandom_range(20, 50);
            for (int k = 0; k < n_casts; k++) begin
                if ($urandom_range(0, 9) == 0)
                    write_cell($urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 255));
                else
                    cast_column(pick_column());
                if (k == n_casts / 2 && $urandom_range(0, 3) == 0) wait_idle();
            end
            wait_idle();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("%0d camera settings, %0d map writes, %0d columns cast", phases + 2,
                 sb.writes, sb.casts);
        $display("%0d wall hits, %0d rays left the map", sb.hits, sb.escapes);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("grid_dda_column_raycaster_top: match");
        end else begin
            $display("%0d errors, %0d results missing", sb.errors, sb.pending());
            $display("grid_dda_column_raycaster_top: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/gdr_pkg.sv
hdl/gdr_div.sv
hdl/gdr_dp.sv
hdl/gdr_ctrl.sv
hdl/grid_dda_column_raycaster_top.sv
hdl/gdr_checker.sv
tb/tb.sv
